// ===== rtl/zbfs_pkg.sv =====
`default_nettype none
package zbfs_pkg;

   // widest bucket index over the legal range of the index width
   localparam int MAX_BUCKET_BITS = 22;

   typedef enum logic [1:0] {
      CMD_INSERT    = 2'd0,
      CMD_SEL_WRITE = 2'd1,
      CMD_QUERY     = 2'd2,
      CMD_CLEAR     = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                      command;
      logic [MAX_BUCKET_BITS-1:0]   bucket;
      logic [6:0]                   sel_word_index;
      logic [31:0]                  sel_word_bits;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/zbfs_queue.sv =====
`default_nettype none
module zbfs_queue
   import zbfs_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           not_empty,
   output entry_type      head_entry
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = count_ff[1];
   assign not_empty  = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ===== rtl/zbfs_front.sv =====
`default_nettype none
module zbfs_front
   import zbfs_pkg::*;
#(
   parameter int INDEX_BITS = 5
) (
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_coord_a,
   input  wire logic [31:0] req_coord_b,
   input  wire logic [6:0]  req_sel_word_index,
   input  wire logic [31:0] req_sel_word_bits,
   input  wire logic [9:0]  req_query_bucket,
   input  wire logic        queue_full,
   input  wire logic        sweeping,
   output logic             push,
   output entry_type        push_entry
);

   localparam int BW = 2 * INDEX_BITS;

   logic [MAX_BUCKET_BITS-1:0] ins_bucket;
   logic [MAX_BUCKET_BITS-1:0] qry_bucket;
   logic [MAX_BUCKET_BITS-1:0] bucket_mask;

   always_comb begin
      bucket_mask = (MAX_BUCKET_BITS'(1) << BW) - MAX_BUCKET_BITS'(1);
      ins_bucket  = MAX_BUCKET_BITS'({req_coord_b[31 -: INDEX_BITS],
                                      req_coord_a[31 -: INDEX_BITS]});
      qry_bucket  = MAX_BUCKET_BITS'(req_query_bucket) & bucket_mask;

      push_entry.command        = cmd_type'(req_command);
      push_entry.sel_word_index = req_sel_word_index;
      push_entry.sel_word_bits  = req_sel_word_bits;
      push_entry.bucket         = (cmd_type'(req_command) == CMD_INSERT) ? ins_bucket
                                                                         : qry_bucket;
   end

   assign busy = queue_full | sweeping;
   assign push = start & ~busy;

endmodule
`default_nettype wire

// ===== rtl/zbfs_back.sv =====
`default_nettype none
module zbfs_back
   import zbfs_pkg::*;
#(
   parameter int INDEX_BITS = 5,
   parameter int MAX_ROWS   = 4096
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire entry_type  q_entry,
   output logic            q_pop,
   output logic            sweeping,
   output logic            rsp_strobe,
   output logic            rsp_status,
   output logic [11:0]     rsp_row_number,
   output logic [9:0]      rsp_bucket_index,
   output logic            rsp_first_in_bucket,
   output logic            rsp_bucket_used,
   output logic            rsp_found
);

   localparam int BW  = 2 * INDEX_BITS;
   localparam int NB  = 1 << BW;
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_ROWS + 1);
   localparam int BKW = 1 + 2 * RW;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_BUCKET = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_SWEEP  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   entry_type         ent_ff, ent_in;
   logic [CW-1:0]     row_count_ff, row_count_in;
   logic [BW-1:0]     sweep_ff, sweep_in;
   logic [RW-1:0]     cur_ff, cur_in;
   logic [RW-1:0]     tail_ff, tail_in;

   logic [BKW-1:0]    bkt_mem [NB];
   logic [BKW-1:0]    bkt_rd_ff;
   logic [RW-1:0]     link_mem [MAX_ROWS];
   logic [RW-1:0]     link_rd_ff;
   logic [31:0]       sel_mem [128];
   logic [31:0]       sel_rd_ff;
   logic              sel_vrd_ff;
   logic              sel_range_ff;
   logic [127:0]      sel_valid_ff;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [11:0]       rsp_row_ff, rsp_row_in;
   logic [9:0]        rsp_bucket_ff, rsp_bucket_in;
   logic              rsp_first_ff, rsp_first_in;
   logic              rsp_used_ff, rsp_used_in;
   logic              rsp_found_ff, rsp_found_in;

   logic              bkt_v;
   logic [RW-1:0]     bkt_head;
   logic [RW-1:0]     bkt_tail;
   logic              table_full;
   logic [RW-1:0]     new_row;
   logic              ins_go;
   logic              walk_re;
   logic [RW-1:0]     walk_addr;
   logic [15:0]       walk_wide;
   logic              bkt_we;
   logic [BW-1:0]     bkt_waddr;
   logic [BKW-1:0]    bkt_wdata;
   logic              sel_we;
   logic              hit;
   logic [15:0]       cur_wide;

   always_comb begin
      bkt_v      = bkt_rd_ff[BKW-1];
      bkt_head   = bkt_rd_ff[2*RW-1:RW];
      bkt_tail   = bkt_rd_ff[RW-1:0];
      table_full = (row_count_ff == CW'(MAX_ROWS));
      new_row    = row_count_ff[RW-1:0];
      ins_go     = (state_ff == ST_BUCKET) && (ent_ff.command == CMD_INSERT) && !table_full;
      walk_addr  = (state_ff == ST_BUCKET) ? bkt_head : link_rd_ff;
      walk_wide  = 16'(walk_addr);
      cur_wide   = 16'(cur_ff);
      hit        = sel_vrd_ff && sel_range_ff && sel_rd_ff[cur_ff[4:0]];

      bkt_we    = (state_ff == ST_SWEEP) || ins_go;
      bkt_waddr = (state_ff == ST_SWEEP) ? sweep_ff : ent_ff.bucket[BW-1:0];
      bkt_wdata = (state_ff == ST_SWEEP) ? BKW'(0)
                                         : {1'b1, (bkt_v ? bkt_head : new_row), new_row};

      state_in      = state_ff;
      ent_in        = ent_ff;
      row_count_in  = row_count_ff;
      sweep_in      = sweep_ff;
      cur_in        = cur_ff;
      tail_in       = tail_ff;
      q_pop         = 1'b0;
      sel_we        = 1'b0;
      walk_re       = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = 1'b0;
      rsp_row_in    = 12'd0;
      rsp_bucket_in = 10'd0;
      rsp_first_in  = 1'b0;
      rsp_used_in   = 1'b0;
      rsp_found_in  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               ent_in = q_entry;
               case (q_entry.command)
                  CMD_SEL_WRITE: begin
                     sel_we        = 1'b1;
                     rsp_strobe_in = 1'b1;
                  end
                  CMD_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     row_count_in  = '0;
                     sweep_in      = '0;
                     state_in      = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_BUCKET;
                  end
               endcase
            end
         end
         ST_BUCKET: begin
            rsp_bucket_in = ent_ff.bucket[9:0];
            if (ent_ff.command == CMD_INSERT) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = table_full;
               if (!table_full) begin
                  rsp_row_in   = 12'(16'(new_row));
                  rsp_first_in = !bkt_v;
                  row_count_in = row_count_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end else if (!bkt_v) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               walk_re  = 1'b1;
               cur_in   = walk_addr;
               tail_in  = bkt_tail;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rsp_bucket_in = ent_ff.bucket[9:0];
            rsp_used_in   = 1'b1;
            if (hit) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_row_in    = cur_wide[11:0];
               state_in      = ST_IDLE;
            end else if (cur_ff == tail_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               walk_re = 1'b1;
               cur_in  = walk_addr;
            end
         end
         ST_SWEEP: begin
            sweep_in = sweep_ff + BW'(1);
            if (sweep_ff == BW'(NB - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         row_count_ff  <= '0;
         sel_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         row_count_ff  <= row_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (sel_we) begin
            sel_valid_ff[ent_in.sel_word_index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff        <= ent_in;
      cur_ff        <= cur_in;
      tail_ff       <= tail_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_found_ff  <= rsp_found_in;
   end

   // bucket table: valid, head, tail per bucket
   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_waddr] <= bkt_wdata;
      end
      if (q_pop) begin
         bkt_rd_ff <= bkt_mem[q_entry.bucket[BW-1:0]];
      end
   end

   // row links, written at the old tail on append
   always_ff @(posedge clock) begin
      if (ins_go && bkt_v) begin
         link_mem[bkt_tail] <= new_row;
      end
      if (walk_re) begin
         link_rd_ff <= link_mem[walk_addr];
      end
   end

   // selection bitmap, unwritten words read as zero
   always_ff @(posedge clock) begin
      if (sel_we) begin
         sel_mem[q_entry.sel_word_index] <= q_entry.sel_word_bits;
      end
      if (walk_re) begin
         sel_rd_ff    <= sel_mem[walk_wide[11:5]];
         sel_vrd_ff   <= sel_valid_ff[walk_wide[11:5]];
         sel_range_ff <= (walk_wide[15:12] == 4'd0);
      end
   end

   assign sweeping            = (state_ff == ST_SWEEP);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_row_number      = rsp_row_ff;
   assign rsp_bucket_index    = rsp_bucket_ff;
   assign rsp_first_in_bucket = rsp_first_ff;
   assign rsp_bucket_used     = rsp_used_ff;
   assign rsp_found           = rsp_found_ff;

endmodule
`default_nettype wire

// ===== rtl/zone_bucket_first_selected.sv =====
// channel    handshake          payload
// request    start / busy       req_command, req_coord_a/b, req_sel_word_*, req_query_bucket
// response   rsp_strobe         rsp_status, rsp_row_number, rsp_bucket_index,
//                               rsp_first_in_bucket, rsp_bucket_used, rsp_found
//
// a two-entry queue sits between the request side and the table engine.
// selection write: written by the engine as it leaves the queue; insert: bucket read, then
// head/tail and link write; query: bucket read, then a walk over the list rows visited.
// clear answers at once, then sweeps 2^(2*INDEX_BITS) bucket entries, one a cycle.
// reset starts the same sweep; busy stays high while it runs.
// busy rises only while the queue is full or a sweep runs; responses are never held.
`default_nettype none
module zone_bucket_first_selected
   import zbfs_pkg::*;
#(
   parameter int INDEX_BITS = 5,
   parameter int MAX_ROWS   = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_coord_a,
   input  wire logic [31:0] req_coord_b,
   input  wire logic [6:0]  req_sel_word_index,
   input  wire logic [31:0] req_sel_word_bits,
   input  wire logic [9:0]  req_query_bucket,
   output logic             rsp_strobe,
   output logic             rsp_status,
   output logic [11:0]      rsp_row_number,
   output logic [9:0]       rsp_bucket_index,
   output logic             rsp_first_in_bucket,
   output logic             rsp_bucket_used,
   output logic             rsp_found
);

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      q_valid;
   entry_type q_entry;
   logic      q_pop;
   logic      sweeping;

   zbfs_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_coord_a        (req_coord_a),
      .req_coord_b        (req_coord_b),
      .req_sel_word_index (req_sel_word_index),
      .req_sel_word_bits  (req_sel_word_bits),
      .req_query_bucket   (req_query_bucket),
      .queue_full         (queue_full),
      .sweeping           (sweeping),
      .push               (push),
      .push_entry         (push_entry)
   );

   zbfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (queue_full),
      .not_empty  (q_valid),
      .head_entry (q_entry)
   );

   zbfs_back #(.INDEX_BITS(INDEX_BITS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_entry             (q_entry),
      .q_pop               (q_pop),
      .sweeping            (sweeping),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_row_number      (rsp_row_number),
      .rsp_bucket_index    (rsp_bucket_index),
      .rsp_first_in_bucket (rsp_first_in_bucket),
      .rsp_bucket_used     (rsp_bucket_used),
      .rsp_found           (rsp_found)
   );

endmodule
`default_nettype wire
